[hdl/qvel_pkg.sv]
package qvel_pkg;

    // Field widths
    localparam int TIMER_W   = 16;
    localparam int TIME_W    = 32;
    localparam int POS_W     = 64;
    localparam int VEL_W     = 32;
    localparam int TD_W      = 16;
    localparam int RPT_W     = 32;
    localparam int MININT_W  = 16;
    localparam int ALPHA_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Default quadrature counter width
    localparam int COUNTER_WIDTH_DEF = 16;

    // Register reset values
    localparam logic [RPT_W-1:0]    TICK_ANGLE_RST   = 32'd0;
    localparam logic [MININT_W-1:0] MIN_INTERVAL_RST = 16'd1000;
    localparam logic [ALPHA_W-1:0]  FILTER_ALPHA_RST = 16'd6554;

    // Microseconds per second
    localparam logic [19:0] US_PER_S = 20'd1000000;

    // Shared multiplier operand width and product width
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // Scaled angle change: mag * 10^6 fits in 83 bits; divider takes it >> 16
    localparam int NUM_W     = 83;
    localparam int DIV_NUM_W = NUM_W - 16;
    localparam int DIV_STEPS = 32;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_ANGLE   = 2'd0,
        CFG_MIN_INTERVAL = 2'd1,
        CFG_FILTER_ALPHA = 2'd2
    } qvel_cfg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_MAG,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_VEL,
        ST_MUL_ALPHA,
        ST_FILT,
        ST_DONE
    } qvel_state_t;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        MSEL_NONE,
        MSEL_MAG,
        MSEL_LO,
        MSEL_HI,
        MSEL_ALPHA
    } qvel_mul_sel_t;

    // Datapath status toward the sequencer
    typedef struct packed {
        logic in_fire;
        logic run;
        logic div_busy;
        logic out_free;
    } qvel_stat_t;

    // Sequencer strobes toward the datapath
    typedef struct packed {
        logic          in_ready;
        qvel_mul_sel_t mul_sel;
        logic          mul_en;
        logic          hi_save;
        logic          pos_update;
        logic          lo_save;
        logic          sum_load;
        logic          div_start;
        logic          vel_prep;
        logic          filt_load;
        logic          out_load;
    } qvel_ctrl_t;

endpackage

[hdl/qvel_ifs.sv]
// Sample channel
interface qvel_in_if;
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [qvel_pkg::TIMER_W-1:0]   timer_count;
    logic [qvel_pkg::TIME_W-1:0]    time_us;

    modport source (output valid, cmd, timer_count, time_us, input ready);
    modport sink   (input valid, cmd, timer_count, time_us, output ready);
endinterface

// Result channel
interface qvel_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [qvel_pkg::POS_W-1:0]  position;
    logic signed [qvel_pkg::VEL_W-1:0]  velocity;
    logic                               updated;
    logic signed [qvel_pkg::TD_W-1:0]   tick_delta;

    modport source (output valid, position, velocity, updated, tick_delta, input ready);
    modport sink   (input valid, position, velocity, updated, tick_delta, output ready);
endinterface

// Register write channel
interface qvel_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [qvel_pkg::CFG_IDX_W-1:0]     index;
    logic [qvel_pkg::CFG_DAT_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/qvel_div.sv]
module qvel_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [qvel_pkg::DIV_NUM_W-1:0]    num,
    input  logic [qvel_pkg::MUL_W-1:0]        den,
    output logic                              busy,
    output logic                              ovf,
    output logic [qvel_pkg::MUL_W-1:0]        quo
);

    localparam int W     = qvel_pkg::MUL_W;
    localparam int CNT_W = $clog2(qvel_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(qvel_pkg::DIV_STEPS - 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     den_reg, den_next;
    logic             ovf_reg, ovf_next;

    logic [W:0]       shifted;
    logic [W:0]       trial;
    logic             ge;

    // One restoring step per cycle
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            // quotient needs more than 32 bits when the top part reaches den
            ovf_next  = (num[qvel_pkg::DIV_NUM_W-1:W] >= (qvel_pkg::DIV_NUM_W-W)'(den));
            rem_next  = num[2*W-1:W];
            quo_next  = num[W-1:0];
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? trial[W-1:0] : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        ovf_reg <= ovf_next;
    end

    assign busy = busy_reg;
    assign ovf  = ovf_reg;
    assign quo  = quo_reg;

endmodule

[hdl/qvel_fsm.sv]
module qvel_fsm (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qvel_pkg::qvel_stat_t stat,
    output qvel_pkg::qvel_ctrl_t ctrl
);

    qvel_pkg::qvel_state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qvel_pkg::ST_IDLE:
            begin
                if (stat.in_fire)
                begin
                    state_next = stat.run ? qvel_pkg::ST_MUL_MAG : qvel_pkg::ST_DONE;
                end
            end
            qvel_pkg::ST_MUL_MAG:   state_next = qvel_pkg::ST_MUL_LO;
            qvel_pkg::ST_MUL_LO:    state_next = qvel_pkg::ST_MUL_HI;
            qvel_pkg::ST_MUL_HI:    state_next = qvel_pkg::ST_SUM;
            qvel_pkg::ST_SUM:       state_next = qvel_pkg::ST_DIV_GO;
            qvel_pkg::ST_DIV_GO:    state_next = qvel_pkg::ST_DIV_WAIT;
            qvel_pkg::ST_DIV_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = qvel_pkg::ST_VEL;
                end
            end
            qvel_pkg::ST_VEL:       state_next = qvel_pkg::ST_MUL_ALPHA;
            qvel_pkg::ST_MUL_ALPHA: state_next = qvel_pkg::ST_FILT;
            qvel_pkg::ST_FILT:      state_next = qvel_pkg::ST_DONE;
            qvel_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = qvel_pkg::ST_IDLE;
                end
            end
            default:                state_next = qvel_pkg::ST_IDLE;
        endcase
    end

    // Strobes
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            qvel_pkg::ST_IDLE:      ctrl.in_ready = 1'b1;
            qvel_pkg::ST_MUL_MAG:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = qvel_pkg::MSEL_MAG;
            end
            qvel_pkg::ST_MUL_LO:
            begin
                ctrl.mul_en     = 1'b1;
                ctrl.mul_sel    = qvel_pkg::MSEL_LO;
                ctrl.hi_save    = 1'b1;
                ctrl.pos_update = 1'b1;
            end
            qvel_pkg::ST_MUL_HI:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = qvel_pkg::MSEL_HI;
                ctrl.lo_save = 1'b1;
            end
            qvel_pkg::ST_SUM:       ctrl.sum_load  = 1'b1;
            qvel_pkg::ST_DIV_GO:    ctrl.div_start = 1'b1;
            qvel_pkg::ST_DIV_WAIT:  ctrl = '0;
            qvel_pkg::ST_VEL:       ctrl.vel_prep  = 1'b1;
            qvel_pkg::ST_MUL_ALPHA:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = qvel_pkg::MSEL_ALPHA;
            end
            qvel_pkg::ST_FILT:      ctrl.filt_load = 1'b1;
            qvel_pkg::ST_DONE:      ctrl.out_load  = stat.out_free;
            default:                ctrl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qvel_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/encoder_position_velocity_estimator.sv]
// Quadrature encoder position and velocity estimator. Each sample transfer carries a
// counter reading and a microsecond timestamp; a sample that comes at least
// min_interval_us after the last accepted one adds the wrap-corrected tick change times
// the per-tick angle (register 0) to a saturating Q31.32 position and low-pass filters
// the new Q16.16 velocity with weight filter_alpha. A reset command (cmd = 1) clears
// position, velocity and the count baseline and takes time_us as the time baseline.
// Every sample or command gives exactly one result. An accepted sample occupies the
// block while the one-bit-per-cycle restoring divider scales angle by elapsed time;
// the three 32x32 products and the filter product share one registered multiplier.
// Commands and rejected samples go straight to the result. Sample ready is
// low while an item is in work; a finished result waits in the output register and does
// not block the next sample unless it is still untaken when the following result is
// due. Register writes are always taken and belong between items.
module encoder_position_velocity_estimator #(
    parameter int COUNTER_WIDTH = qvel_pkg::COUNTER_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    qvel_in_if.sink     sample,
    qvel_out_if.source  result,
    qvel_cfg_if.sink    cfg
);

    localparam int CW = COUNTER_WIDTH;
    localparam int W  = qvel_pkg::MUL_W;

    // Configuration registers
    logic [qvel_pkg::RPT_W-1:0]    rpt_reg;
    logic [qvel_pkg::MININT_W-1:0] min_int_reg;
    logic [qvel_pkg::ALPHA_W-1:0]  alpha_reg;

    // Estimator state
    logic [CW-1:0]                 last_count_reg;
    logic [qvel_pkg::TIME_W-1:0]   last_time_reg;
    logic signed [qvel_pkg::POS_W-1:0] pos_reg, pos_next;
    logic signed [qvel_pkg::VEL_W-1:0] vel_reg, vel_next;

    // Per-item working registers
    logic                          upd_reg;
    logic signed [qvel_pkg::TD_W-1:0] td_reg;
    logic                          neg_reg;
    logic [W-1:0]                  dmag_reg;
    logic [W-1:0]                  dt_reg;
    logic [qvel_pkg::PROD_W-1:0]   prod_reg;
    logic [W-1:0]                  mag_hi_reg;
    logic [51:0]                   nlo_reg;
    logic [qvel_pkg::NUM_W-1:0]    num_reg;
    logic [W-1:0]                  dm_reg;
    logic                          dneg_reg;

    // Output register
    logic                          out_valid_reg;
    logic signed [qvel_pkg::POS_W-1:0] out_pos_reg;
    logic signed [qvel_pkg::VEL_W-1:0] out_vel_reg;
    logic                          out_upd_reg;
    logic signed [qvel_pkg::TD_W-1:0]  out_td_reg;

    qvel_pkg::qvel_stat_t stat;
    qvel_pkg::qvel_ctrl_t ctrl;

    logic                          in_fire;
    logic [CW-1:0]                 cnt_w;
    logic [CW-1:0]                 cnt_diff;
    logic signed [W:0]             dsx;
    logic                          d_neg;
    logic [W-1:0]                  d_mag;
    logic signed [qvel_pkg::TD_W-1:0] d_sat;
    logic [qvel_pkg::TIME_W-1:0]   dt;
    logic                          dt_ok;

    logic [W-1:0]                  mul_a, mul_b;
    logic signed [qvel_pkg::POS_W:0] pos_sum;
    logic [qvel_pkg::NUM_W-1:0]    num_next;

    logic                          div_busy, div_ovf;
    logic [W-1:0]                  div_quo;
    logic [W:0]                    vm;
    logic signed [qvel_pkg::VEL_W-1:0] raw;
    logic signed [W:0]             vdiff;
    logic [W-1:0]                  step;

    // Counter reading at the configured width
    generate
        if (CW > qvel_pkg::TIMER_W)
        begin : g_cnt_wide
            assign cnt_w = {{(CW - qvel_pkg::TIMER_W){1'b0}}, sample.timer_count};
        end
        else
        begin : g_cnt_narrow
            assign cnt_w = sample.timer_count[CW-1:0];
        end
    endgenerate

    // Tick change, sign-extended, with magnitude and 16-bit saturated view
    assign cnt_diff = cnt_w - last_count_reg;
    assign dsx      = (W+1)'($signed(cnt_diff));
    assign d_neg    = dsx[W];
    assign d_mag    = d_neg ? W'(-dsx) : W'(dsx);

    always_comb
    begin
        if (dsx > (W+1)'(32767))
        begin
            d_sat = 16'sh7fff;
        end
        else if (dsx < -(W+1)'(32768))
        begin
            d_sat = 16'sh8000;
        end
        else
        begin
            d_sat = dsx[qvel_pkg::TD_W-1:0];
        end
    end

    // Interval check
    assign dt    = sample.time_us - last_time_reg;
    assign dt_ok = (dt >= {{(qvel_pkg::TIME_W - qvel_pkg::MININT_W){1'b0}}, min_int_reg});

    assign in_fire       = ctrl.in_ready && sample.valid;
    assign stat.in_fire  = in_fire;
    assign stat.run      = !sample.cmd && dt_ok;
    assign stat.div_busy = div_busy;
    assign stat.out_free = !out_valid_reg || result.ready;

    qvel_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // Register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpt_reg     <= qvel_pkg::TICK_ANGLE_RST;
            min_int_reg <= qvel_pkg::MIN_INTERVAL_RST;
            alpha_reg   <= qvel_pkg::FILTER_ALPHA_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                qvel_pkg::CFG_TICK_ANGLE:   rpt_reg     <= cfg.data[qvel_pkg::RPT_W-1:0];
                qvel_pkg::CFG_MIN_INTERVAL: min_int_reg <= cfg.data[qvel_pkg::MININT_W-1:0];
                qvel_pkg::CFG_FILTER_ALPHA: alpha_reg   <= cfg.data[qvel_pkg::ALPHA_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Shared multiplier operands
    always_comb
    begin
        mul_a = dmag_reg;
        mul_b = rpt_reg;
        case (ctrl.mul_sel)
            qvel_pkg::MSEL_LO:
            begin
                mul_a = prod_reg[W-1:0];
                mul_b = W'(qvel_pkg::US_PER_S);
            end
            qvel_pkg::MSEL_HI:
            begin
                mul_a = mag_hi_reg;
                mul_b = W'(qvel_pkg::US_PER_S);
            end
            qvel_pkg::MSEL_ALPHA:
            begin
                mul_a = dm_reg;
                mul_b = W'(alpha_reg);
            end
            default:
            begin
                mul_a = dmag_reg;
                mul_b = rpt_reg;
            end
        endcase
    end

    // Saturating position update with the angle change held in prod_reg
    always_comb
    begin
        if (neg_reg)
        begin
            pos_sum = (qvel_pkg::POS_W+1)'(pos_reg) - $signed({1'b0, prod_reg});
        end
        else
        begin
            pos_sum = (qvel_pkg::POS_W+1)'(pos_reg) + $signed({1'b0, prod_reg});
        end
        if (pos_sum[qvel_pkg::POS_W] != pos_sum[qvel_pkg::POS_W-1])
        begin
            pos_next = pos_sum[qvel_pkg::POS_W] ? {1'b1, {(qvel_pkg::POS_W-1){1'b0}}}
                                                : {1'b0, {(qvel_pkg::POS_W-1){1'b1}}};
        end
        else
        begin
            pos_next = pos_sum[qvel_pkg::POS_W-1:0];
        end
    end

    // angle * 10^6 from the two partial products
    assign num_next = {prod_reg[50:0], {W{1'b0}}} + qvel_pkg::NUM_W'(nlo_reg);

    qvel_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.div_start),
        .num   (num_reg[qvel_pkg::NUM_W-1:16]),
        .den   (dt_reg),
        .busy  (div_busy),
        .ovf   (div_ovf),
        .quo   (div_quo)
    );

    // Raw velocity with saturation, then distance to the filtered value
    always_comb
    begin
        vm = div_ovf ? {1'b1, {W{1'b0}}} : {1'b0, div_quo};
        if (neg_reg)
        begin
            raw = (vm > (W+1)'(33'h0_8000_0000)) ? {1'b1, {(W-1){1'b0}}} : W'(-vm);
        end
        else
        begin
            raw = (vm > (W+1)'(33'h0_7fff_ffff)) ? {1'b0, {(W-1){1'b1}}} : vm[W-1:0];
        end
        vdiff = (W+1)'(raw) - (W+1)'(vel_reg);
    end

    // Filter step lies between prev and raw, so 32-bit wrap is exact
    assign step = prod_reg[W+15:16];
    assign vel_next = dneg_reg ? (vel_reg - $signed(step)) : (vel_reg + $signed(step));

    // Estimator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
            last_time_reg  <= '0;
            pos_reg        <= '0;
            vel_reg        <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                if (sample.cmd)
                begin
                    last_count_reg <= '0;
                    last_time_reg  <= sample.time_us;
                    pos_reg        <= '0;
                    vel_reg        <= '0;
                end
                else if (dt_ok)
                begin
                    last_count_reg <= cnt_w;
                    last_time_reg  <= sample.time_us;
                end
            end
            if (ctrl.pos_update)
            begin
                pos_reg <= pos_next;
            end
            if (ctrl.filt_load)
            begin
                vel_reg <= vel_next;
            end
        end
    end

    // Per-item working registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            upd_reg  <= stat.run;
            td_reg   <= stat.run ? d_sat : '0;
            neg_reg  <= d_neg;
            dmag_reg <= d_mag;
            dt_reg   <= (dt == '0) ? W'(1) : dt;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= qvel_pkg::PROD_W'(mul_a) * qvel_pkg::PROD_W'(mul_b);
        end
        if (ctrl.hi_save)
        begin
            mag_hi_reg <= prod_reg[qvel_pkg::PROD_W-1:W];
        end
        if (ctrl.lo_save)
        begin
            nlo_reg <= prod_reg[51:0];
        end
        if (ctrl.sum_load)
        begin
            num_reg <= num_next;
        end
        if (ctrl.vel_prep)
        begin
            dneg_reg <= vdiff[W];
            dm_reg   <= vdiff[W] ? W'(-vdiff) : vdiff[W-1:0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_pos_reg <= pos_reg;
            out_vel_reg <= vel_reg;
            out_upd_reg <= upd_reg;
            out_td_reg  <= td_reg;
        end
    end

    assign sample.ready      = ctrl.in_ready;
    assign result.valid      = out_valid_reg;
    assign result.position   = out_pos_reg;
    assign result.velocity   = out_vel_reg;
    assign result.updated    = out_upd_reg;
    assign result.tick_delta = out_td_reg;

endmodule

[bench/encoder_position_velocity_estimator_test.sv]
`timescale 1ns / 1ps

module encoder_position_velocity_estimator_test;

    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 150;
    localparam int SETTLE      = 64;
    // index past the register list, must be ignored
    localparam logic [qvel_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // above this whole quotient (angle per microsecond) the speed is capped at 2^32
    localparam logic [63:0] SPEED_CAP = (64'd1 << 48) / 64'd1000000;

    typedef struct {
        logic signed [qvel_pkg::POS_W-1:0] position;
        logic signed [qvel_pkg::VEL_W-1:0] velocity;
        logic                              updated;
        logic signed [qvel_pkg::TD_W-1:0]  tick_delta;
    } motion_t;

    // Tracks encoder state and holds the motion each transfer should produce
    class motion_tracker;
        bit [qvel_pkg::RPT_W-1:0]    tick_angle;
        bit [qvel_pkg::MININT_W-1:0] min_interval;
        bit [qvel_pkg::ALPHA_W-1:0]  alpha;
        bit [qvel_pkg::TIMER_W-1:0]  last_count;
        bit [qvel_pkg::TIME_W-1:0]   last_time;
        longint                      position;
        int                          velocity;
        motion_t                     awaited[$];
        int                          errors;
        int                          updates;
        int                          rejects;
        int                          resets;
        int                          results;

        function new();
            tick_angle   = qvel_pkg::TICK_ANGLE_RST;
            min_interval = qvel_pkg::MIN_INTERVAL_RST;
            alpha        = qvel_pkg::FILTER_ALPHA_RST;
            last_count   = '0;
            last_time    = '0;
            position     = 0;
            velocity     = 0;
            errors       = 0;
            updates      = 0;
            rejects      = 0;
            resets       = 0;
            results      = 0;
        endfunction

        function void set_register(logic [qvel_pkg::CFG_IDX_W-1:0] idx,
                                   logic [qvel_pkg::CFG_DAT_W-1:0] value);
            case (idx)
                qvel_pkg::CFG_TICK_ANGLE:   tick_angle = value;
                qvel_pkg::CFG_MIN_INTERVAL: min_interval = value[qvel_pkg::MININT_W-1:0];
                qvel_pkg::CFG_FILTER_ALPHA: alpha = value[qvel_pkg::ALPHA_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(bit cmd, bit [qvel_pkg::TIMER_W-1:0] cnt,
                                  bit [qvel_pkg::TIME_W-1:0] now);
            motion_t                          want;
            bit [qvel_pkg::TIME_W-1:0]        elapsed;
            logic signed [qvel_pkg::TD_W-1:0] ticks;
            bit [16:0]                        tick_mag;
            bit [63:0]                        angle, span, whole, rest, speed, dm, step;
            bit signed [64:0]                 wide;
            longint                           raw, prev, diff;
            bit                               upd;

            ticks = '0;
            upd   = 1'b0;
            elapsed = now - last_time;
            if (cmd) begin
                position   = 0;
                velocity   = 0;
                last_count = '0;
                last_time  = now;
                resets++;
            end else if (elapsed < min_interval) begin
                rejects++;
            end else begin
                // wrap-corrected tick change and its magnitude
                ticks    = cnt - last_count;
                tick_mag = ticks[15] ? 17'h10000 - {1'b0, ticks} : {1'b0, ticks};
                angle    = tick_mag * tick_angle;

                // saturating position
                wide = ticks[15] ? {position[63], position} - {1'b0, angle}
                                 : {position[63], position} + {1'b0, angle};
                if (wide[64] != wide[63])
                    position = ticks[15] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                else
                    position = wide[63:0];

                // raw speed in Q16.16, zero elapsed time counts as one microsecond
                span  = (elapsed == 0) ? 64'd1 : 64'(elapsed);
                whole = angle / span;
                rest  = angle % span;
                speed = (whole > SPEED_CAP) ? (64'd1 << 32)
                        : (whole * qvel_pkg::US_PER_S + rest * qvel_pkg::US_PER_S / span)
                          >> 16;
                if (ticks[15])
                    raw = (speed > 64'd2147483648) ? -64'sd2147483648 : -longint'(speed);
                else
                    raw = (speed > 64'd2147483647) ? 64'sd2147483647 : longint'(speed);

                // low-pass step, truncated toward zero
                prev = velocity;
                diff = raw - prev;
                dm   = (diff < 0) ? -diff : diff;
                step = (dm * alpha) >> 16;
                velocity = int'((diff < 0) ? prev - longint'(step) : prev + longint'(step));

                last_count = cnt;
                last_time  = now;
                upd        = 1'b1;
                updates++;
            end
            want.position   = position;
            want.velocity   = velocity;
            want.updated    = upd;
            want.tick_delta = ticks;
            awaited.push_back(want);
        endfunction

        function void compare(string field, logic signed [63:0] want, logic signed [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(motion_t got);
            motion_t want;
            results++;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result transfer with no sample waiting for it", $time);
                return;
            end
            want = awaited.pop_front();
            compare("position", want.position, got.position);
            compare("velocity", want.velocity, got.velocity);
            compare("updated", want.updated, got.updated);
            compare("tick_delta", want.tick_delta, got.tick_delta);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    qvel_in_if  sample_ch();
    qvel_out_if result_ch();
    qvel_cfg_if cfg_ch();

    motion_tracker tracker = new();

    int                         src_idle_pct;
    int                         sink_idle_pct;
    bit                         hold_token;
    bit [qvel_pkg::TIME_W-1:0]  t_cur;
    bit [qvel_pkg::TIMER_W-1:0] cnt_cur;
    int                         cfg_writes;
    int                         quiet;

    encoder_position_velocity_estimator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #2 clk = ~clk;

    // Result side: check every transfer, stall at random or for a long hold
    initial
    begin
        motion_t seen;
        bit      hold_seen;
        int      hold_left;

        hold_seen = 1'b0;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
                seen.position   = result_ch.position;
                seen.velocity   = result_ch.velocity;
                seen.updated    = result_ch.updated;
                seen.tick_delta = result_ch.tick_delta;
                tracker.check_result(seen);
            end
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("encoder_position_velocity_estimator regression: fail");
                $finish;
            end
        end
    end

    task automatic push_sample(bit cmd, bit [qvel_pkg::TIMER_W-1:0] cnt,
                               bit [qvel_pkg::TIME_W-1:0] now);
        while ($urandom_range(99) < src_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.cmd         <= cmd;
        sample_ch.timer_count <= cnt;
        sample_ch.time_us     <= now;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        tracker.note_sample(cmd, cnt, now);
    endtask

    // Stop offering samples and wait for every pending result
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [qvel_pkg::CFG_IDX_W-1:0] idx,
                             logic [qvel_pkg::CFG_DAT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        tracker.set_register(idx, value);
        cfg_writes++;
    endtask

    task automatic load_settings(bit [qvel_pkg::RPT_W-1:0] rpt,
                                 bit [qvel_pkg::MININT_W-1:0] minint,
                                 bit [qvel_pkg::ALPHA_W-1:0] alpha, bit with_spare);
        write_reg(qvel_pkg::CFG_TICK_ANGLE, rpt);
        write_reg(qvel_pkg::CFG_MIN_INTERVAL, {16'($urandom), minint});
        write_reg(qvel_pkg::CFG_FILTER_ALPHA, {16'($urandom), alpha});
        if (with_spare)
            write_reg(CFG_SPARE, $urandom);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly steady encoder motion, with resets, out-of-interval samples and noise
    task automatic run_items(int count);
        int                        pick;
        int unsigned               mag;
        bit [qvel_pkg::TIME_W-1:0] gap;

        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                // external counter is cleared along with the command
                t_cur   += $urandom_range(100);
                cnt_cur = '0;
                push_sample(1'b1, 16'($urandom), t_cur);
            end else if (pick < 10) begin
                t_cur   = $urandom;
                cnt_cur = 16'($urandom);
                push_sample(1'b0, cnt_cur, t_cur);
            end else begin
                if (tracker.min_interval != 0 && $urandom_range(99) < 15)
                    gap = $urandom_range(tracker.min_interval - 1);
                else
                    gap = tracker.min_interval + $urandom_range(tracker.min_interval / 4 + 50);
                case ($urandom_range(9))
                    0:       mag = $urandom_range(32768, 32767);
                    1, 2:    mag = $urandom_range(32767);
                    3, 4, 5: mag = $urandom_range(2000);
                    default: mag = $urandom_range(20);
                endcase
                t_cur   += gap;
                cnt_cur += $urandom_range(1) ? 16'(-mag) : 16'(mag);
                push_sample(1'b0, cnt_cur, t_cur);
            end
        end
    endtask

    initial
    begin
        bit [qvel_pkg::RPT_W-1:0]    rpt;
        bit [qvel_pkg::MININT_W-1:0] minint;
        bit [qvel_pkg::ALPHA_W-1:0]  alpha;

        rst_n                 <= 1'b0;
        sample_ch.valid       <= 1'b0;
        sample_ch.cmd         <= 1'b0;
        sample_ch.timer_count <= '0;
        sample_ch.time_us     <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= qvel_pkg::CFG_TICK_ANGLE;
        cfg_ch.data           <= '0;
        hold_token            <= 1'b0;
        sink_idle_pct         <= 83;
        src_idle_pct = 36;
        cfg_writes   = 0;
        quiet        = 0;
        t_cur        = '0;
        cnt_cur      = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: one sample short of the interval, one exactly on it
        push_sample(1'b0, 16'h0005, 32'd999);
        push_sample(1'b0, 16'h0005, 32'd1000);
        push_sample(1'b1, 16'hFFFF, 32'd1500);
        drain_results();

        // Largest scale, no interval, full filter weight: saturation and wrap
        load_settings(32'hFFFF_FFFF, 16'd0, 16'hFFFF, 1'b1);
        push_sample(1'b0, 16'h0001, 32'd1500);
        push_sample(1'b0, 16'h8000, 32'd1501);
        push_sample(1'b0, 16'h0000, 32'd1502);
        push_sample(1'b0, 16'hFFFF, 32'd1600);
        push_sample(1'b0, 16'h0000, 32'd1700);
        push_sample(1'b0, 16'h0000, 32'd1800);
        push_sample(1'b1, 16'h0000, 32'hFFFF_FFF0);
        push_sample(1'b0, 16'h0100, 32'h0000_0010);
        push_sample(1'b0, 16'h0080, 32'h0000_000F);
        drain_results();

        // Longest interval, filter frozen
        load_settings(32'd1, 16'hFFFF, 16'd0, 1'b0);
        push_sample(1'b1, 16'h0000, 32'd0);
        push_sample(1'b0, 16'h0010, 32'd65534);
        push_sample(1'b0, 16'h0010, 32'd65535);
        push_sample(1'b0, 16'h7FFF, 32'hFFFF_FFFF);
        drain_results();
        t_cur   = 32'hFFFF_FFFF;
        cnt_cur = 16'h7FFF;

        // Random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            if (phase == PHASES / 3) begin
                src_idle_pct = 83;
                sink_idle_pct <= 36;
            end else if (phase == 2 * PHASES / 3) begin
                src_idle_pct = 0;
                sink_idle_pct <= 0;
            end
            case ($urandom_range(3))
                0:       rpt = '0;
                1:       rpt = 32'hFFFF_FFFF;
                2:       rpt = $urandom;
                default: rpt = $urandom_range(1 << 20, 1);
            endcase
            case ($urandom_range(3))
                0:       minint = '0;
                1:       minint = 16'hFFFF;
                2:       minint = $urandom_range(2000, 1);
                default: minint = $urandom_range(65535);
            endcase
            case ($urandom_range(3))
                0:       alpha = '0;
                1:       alpha = 16'hFFFF;
                2:       alpha = qvel_pkg::FILTER_ALPHA_RST;
                default: alpha = $urandom_range(65535);
            endcase
            load_settings(rpt, minint, alpha, $urandom_range(1));
            // result side holds off while samples keep coming, filling the block
            if (phase == 2 * PHASES / 3)
                hold_token <= ~hold_token;
            run_items(PHASE_ITEMS);
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d samples: %0d updates, %0d inside the interval, %0d reset commands",
                 tracker.updates + tracker.rejects + tracker.resets, tracker.updates,
                 tracker.rejects, tracker.resets);
        $display("%0d register writes over %0d settings, %0d results checked, %0d mismatches",
                 cfg_writes, PHASES + 2, tracker.results, tracker.errors);
        if (tracker.errors == 0 && tracker.awaited.size() == 0)
            $display("encoder_position_velocity_estimator regression: pass");
        else
            $display("encoder_position_velocity_estimator regression: fail");
        $finish;
    end

endmodule
